@@ hdl/bsa_pkg.sv @@
// shared types, codes and the find-first-zero helper of the slot allocator
package bsa_pkg;

   localparam int WORD_BITS    = 64;
   localparam int BIT_IDX_W    = 6;
   localparam int SLOT_INDEX_W = 14;
   localparam int GRANT_W      = 13;
   localparam int STATUS_W     = 3;

   typedef logic [WORD_BITS-1:0]    word_type;
   typedef logic [BIT_IDX_W-1:0]    bit_idx_type;
   typedef logic [SLOT_INDEX_W-1:0] slot_index_type;
   typedef logic [GRANT_W-1:0]      grant_type;
   typedef logic [STATUS_W-1:0]     status_type;

   // request opcodes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // response status codes
   localparam status_type ST_GRANTED  = 3'd0;
   localparam status_type ST_FULL     = 3'd1;
   localparam status_type ST_DISABLED = 3'd2;
   localparam status_type ST_FREED    = 3'd3;
   localparam status_type ST_RANGE    = 3'd4;

   // lowest clear bit of a word: pick the lowest byte with a hole, then the bit in it
   function automatic bit_idx_type lowest_zero(word_type used);
      logic [7:0] byte_free;
      logic [2:0] byte_sel;
      logic [7:0] sel_byte;
      logic [2:0] bit_pos;
      for (int i = 0; i < 8; i++) begin
         byte_free[i] = ~&used[8*i +: 8];
      end
      byte_sel = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (byte_free[i]) begin
            byte_sel = 3'(i);
         end
      end
      sel_byte = used[8*byte_sel +: 8];
      bit_pos = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!sel_byte[i]) begin
            bit_pos = 3'(i);
         end
      end
      return {byte_sel, bit_pos};
   endfunction

endpackage

@@ hdl/bsa_ram.sv @@
// generic single-port-write, single-port-read ram with registered read data
module bsa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bitmap_slot_allocator.sv @@
// bitmap slot allocator: circular find-first-zero scan over a word ram
//
//   channel    ports                                   handshake
//   request    req_opcode, req_slot_index              start & !busy
//   response   rsp_status, rsp_granted_slot            rsp_valid, one cycle
//   csr        csr_wr_data (alloc_enable)              csr_wr_en
//
// after reset the ram is swept to zero, one word at a time with busy high.
// allocate: the hint word is read first, then one word per cycle goes through
// the shared word checker until a free slot is found or, when full, all
// WORD_COUNT words have been examined. free: the word is read, then written back.
// disabled allocate and out-of-range free answer in the cycle after accept.
// the receiver cannot stall; busy drops in the cycle the response shows.
module bitmap_slot_allocator #(
   parameter int WORD_COUNT = 128,
   parameter int SLOT_COUNT = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_opcode,
   input  bsa_pkg::slot_index_type req_slot_index,
   output logic                    rsp_valid,
   output bsa_pkg::status_type     rsp_status,
   output bsa_pkg::grant_type      rsp_granted_slot,
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data
);
   import bsa_pkg::*;

   localparam int WW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int FULL_WORDS = SLOT_COUNT / WORD_BITS;
   localparam int TAIL_BITS  = SLOT_COUNT % WORD_BITS;
   localparam logic [WW-1:0] LAST_WORD = WW'(WORD_COUNT - 1);

   // sequencer states
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_FREE  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [WW-1:0] word_ff, word_in;
   logic [WW-1:0] count_ff, count_in;
   logic [WW-1:0] hint_ff, hint_in;
   bit_idx_type bit_ff, bit_in;
   logic        enable_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   grant_type   rsp_slot_ff, rsp_slot_in;

   logic        accept;
   logic [WW-1:0] req_word;
   logic        req_out_of_range;
   logic [WW-1:0] next_word;
   word_type    ram_rdata;
   word_type    beyond;
   word_type    used;
   logic        has_free;
   bit_idx_type free_bit;
   logic        wr_en;
   logic [WW-1:0] wr_addr;
   word_type    wr_data;
   logic [WW-1:0] rd_addr;

   // bitmap storage
   bsa_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(WORD_COUNT)
   ) u_bitmap (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_rdata)
   );

   // request decode
   assign accept   = start && (state_ff == S_IDLE);
   assign req_word = WW'(req_slot_index >> BIT_IDX_W);
   assign req_out_of_range = (32'(req_slot_index) >= SLOT_COUNT) ||
                             (32'(req_slot_index >> BIT_IDX_W) >= WORD_COUNT);
   assign next_word = (word_ff == LAST_WORD) ? '0 : word_ff + 1'b1;

   // slots at or above the slot count read as taken
   always_comb begin
      if (32'(word_ff) < FULL_WORDS) begin
         beyond = '0;
      end else if ((32'(word_ff) == FULL_WORDS) && (TAIL_BITS != 0)) begin
         beyond = ~((word_type'(1) << TAIL_BITS) - word_type'(1));
      end else begin
         beyond = '1;
      end
   end

   // shared word checker
   assign used     = ram_rdata | beyond;
   assign has_free = ~&used;
   assign free_bit = lowest_zero(used);

   // ram read address
   always_comb begin
      case (state_ff)
         S_IDLE: begin
            rd_addr = (req_opcode == OP_ALLOC) ? hint_ff : req_word;
         end
         S_SCAN: begin
            rd_addr = next_word;
         end
         default: begin
            rd_addr = word_ff;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      count_in      = count_ff;
      hint_in       = hint_ff;
      bit_in        = bit_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;
      case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == OP_ALLOC) begin
                  if (!enable_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_DISABLED;
                     rsp_slot_in   = '0;
                  end else begin
                     word_in  = hint_ff;
                     count_in = '0;
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_out_of_range) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_RANGE;
                     rsp_slot_in   = '0;
                  end else begin
                     word_in  = req_word;
                     bit_in   = req_slot_index[BIT_IDX_W-1:0];
                     state_in = S_FREE;
                  end
               end
            end
         end
         S_SCAN: begin
            if (has_free) begin
               wr_en         = 1'b1;
               wr_data       = ram_rdata | (word_type'(1) << free_bit);
               hint_in       = word_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_GRANTED;
               rsp_slot_in   = GRANT_W'({word_ff, free_bit});
               state_in      = S_IDLE;
            end else if (count_ff == LAST_WORD) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_FULL;
               rsp_slot_in   = '0;
               state_in      = S_IDLE;
            end else begin
               word_in  = next_word;
               count_in = count_ff + 1'b1;
            end
         end
         S_FREE: begin
            wr_en         = 1'b1;
            wr_data       = ram_rdata & ~(word_type'(1) << bit_ff);
            hint_in       = word_ff;
            rsp_valid_in  = 1'b1;
            rsp_status_in = ST_FREED;
            rsp_slot_in   = '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         hint_ff      <= '0;
         enable_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            enable_ff <= csr_wr_data;
         end
      end
   end

   // working and response word registers
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      bit_ff        <= bit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_slot = rsp_slot_ff;

   // checks
   a_rsp_only_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("response shown while sequencer busy");

   a_hint_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(hint_ff) < WORD_COUNT)
      else $error("scan hint beyond word count");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_valid_ff || busy))
      else $error("accepted request neither answered nor in progress");

   a_grant_slot_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == ST_GRANTED)) |-> (32'(rsp_slot_ff) < SLOT_COUNT))
      else $error("granted slot beyond slot count");

   a_nogrant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_GRANTED)) |-> (rsp_slot_ff == '0))
      else $error("slot field nonzero without a grant");

endmodule

@@ verif/tb_bitmap_slot_allocator.sv @@
// self-checking testbench for the bitmap slot allocator
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator;
   import bsa_pkg::*;

   localparam int WORD_COUNT  = 128;
   localparam int SLOT_COUNT  = 8192;
   localparam int INDEX_MAX   = (1 << SLOT_INDEX_W) - 1;
   localparam int CYCLE_LIMIT = 4000000;

   // one reply word as the block returns it
   typedef struct packed {
      status_type status;
      grant_type  slot;
   } reply_type;

   // directed table rows: a request word or a write of the enable register
   typedef enum logic {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      logic           csr_val;
      logic           op;
      slot_index_type idx;
      logic           has_value;
      status_type     status;
      grant_type      slot;
   } dir_row_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   logic           start = 1'b0;
   logic           busy;
   logic           req_opcode = OP_ALLOC;
   slot_index_type req_slot_index = '0;
   logic           rsp_valid;
   status_type     rsp_status;
   grant_type      rsp_granted_slot;
   logic           csr_wr_en = 1'b0;
   logic           csr_wr_data = 1'b0;

   // shadow copy of the slot table
   word_type    shadow_map [WORD_COUNT];
   int unsigned shadow_hint;
   logic        shadow_enable;

   reply_type   replies_due [$];
   int unsigned held_slots [$];
   dir_row_type dir_rows [$];
   int          mismatch_count = 0;
   int unsigned cycle_count = 0;

   bitmap_slot_allocator #(
      .WORD_COUNT (WORD_COUNT),
      .SLOT_COUNT (SLOT_COUNT)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_slot_index   (req_slot_index),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_granted_slot (rsp_granted_slot),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // reply of the slot table to one request, updating the shadow state
   function automatic reply_type slot_table_reply(logic op, slot_index_type idx);
      reply_type   res;
      word_type    used;
      int unsigned w;
      int unsigned b;
      bit          found;
      res.status = ST_FULL;
      res.slot   = '0;
      found      = 1'b0;
      if (op == OP_ALLOC) begin
         if (!shadow_enable) begin
            res.status = ST_DISABLED;
         end else begin
            for (int i = 0; i < WORD_COUNT && !found; i++) begin
               w    = (shadow_hint + i) % WORD_COUNT;
               used = shadow_map[w];
               // slots past the end of the table count as taken
               if ((w + 1) * WORD_BITS > SLOT_COUNT) begin
                  for (int k = 0; k < WORD_BITS; k++) begin
                     if (w * WORD_BITS + k >= SLOT_COUNT) begin
                        used[k] = 1'b1;
                     end
                  end
               end
               if (used != '1) begin
                  b = 0;
                  while (used[b]) begin
                     b++;
                  end
                  shadow_map[w][b] = 1'b1;
                  shadow_hint      = w;
                  res.status       = ST_GRANTED;
                  res.slot         = grant_type'(w * WORD_BITS + b);
                  found            = 1'b1;
               end
            end
         end
      end else begin
         w = idx / WORD_BITS;
         b = idx % WORD_BITS;
         if (idx >= SLOT_COUNT || w >= WORD_COUNT) begin
            res.status = ST_RANGE;
         end else begin
            shadow_map[w][b] = 1'b0;
            shadow_hint      = w;
            res.status       = ST_FREED;
         end
      end
      return res;
   endfunction

   // slot to free: mostly one we hold, else any in-range slot, out of range or extreme
   function automatic slot_index_type pick_free_index();
      int unsigned    roll;
      int unsigned    k;
      slot_index_type idx;
      roll = $urandom_range(99);
      if (roll < 60 && held_slots.size() != 0) begin
         k   = $urandom_range(held_slots.size() - 1);
         idx = slot_index_type'(held_slots[k]);
         held_slots.delete(k);
      end else if (roll < 75) begin
         idx = slot_index_type'($urandom_range(SLOT_COUNT - 1));
      end else if (roll < 85) begin
         idx = slot_index_type'($urandom);
      end else if (roll < 95) begin
         idx = slot_index_type'($urandom_range(INDEX_MAX, SLOT_COUNT));
      end else begin
         case ($urandom_range(3))
            0: idx = '0;
            1: idx = slot_index_type'(SLOT_COUNT - 1);
            2: idx = slot_index_type'(SLOT_COUNT);
            default: idx = '1;
         endcase
      end
      return idx;
   endfunction

   task automatic add_word_row(logic op, slot_index_type idx, logic has_value,
                               status_type status, grant_type slot);
      dir_row_type row;
      row.kind      = ROW_WORD;
      row.csr_val   = 1'b0;
      row.op        = op;
      row.idx       = idx;
      row.has_value = has_value;
      row.status    = status;
      row.slot      = slot;
      dir_rows.push_back(row);
   endtask

   task automatic add_csr_row(logic val);
      dir_row_type row;
      row           = '0;
      row.kind      = ROW_CSR;
      row.csr_val   = val;
      dir_rows.push_back(row);
   endtask

   // offer one request word, wait for acceptance, then maybe idle
   task automatic send_word(logic op, slot_index_type idx, logic has_value,
                            status_type status, grant_type slot, int idle_pct);
      reply_type predicted;
      reply_type typed_in;
      req_opcode     <= op;
      req_slot_index <= idx;
      start          <= 1'b1;
      @(posedge clock);
      while (busy !== 1'b0 || reset) begin
         @(posedge clock);
      end
      predicted = slot_table_reply(op, idx);
      if (predicted.status == ST_GRANTED) begin
         held_slots.push_back(predicted.slot);
      end
      if (has_value) begin
         typed_in.status = status;
         typed_in.slot   = slot;
         replies_due.push_back(typed_in);
      end else begin
         replies_due.push_back(predicted);
      end
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(7, 1)) @(posedge clock);
      end
   endtask

   task automatic random_item(int alloc_pct, int idle_pct);
      if ($urandom_range(99) < alloc_pct) begin
         send_word(OP_ALLOC, slot_index_type'($urandom), 1'b0, ST_GRANTED, '0, idle_pct);
      end else begin
         send_word(OP_FREE, pick_free_index(), 1'b0, ST_GRANTED, '0, idle_pct);
      end
   endtask

   // enable register write, only once the block has drained
   task automatic set_alloc_enable(logic val);
      start <= 1'b0;
      while (replies_due.size() != 0 || busy !== 1'b0) begin
         @(posedge clock);
      end
      csr_wr_en   <= 1'b1;
      csr_wr_data <= val;
      @(posedge clock);
      shadow_enable = val;
      csr_wr_en   <= 1'b0;
   endtask

   task automatic note_mismatch(string field, logic [15:0] want, logic [15:0] got);
      mismatch_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, field, want, got);
   endtask

   // reply checker: every reply word against the oldest one due
   always @(posedge clock) begin : check_reply
      reply_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (replies_due.size() == 0) begin
            mismatch_count++;
            $display("%0t ns: reply word with none due, actual status %0d slot %0d",
                     $time, rsp_status, rsp_granted_slot);
         end else begin
            want = replies_due.pop_front();
            if (rsp_status !== want.status) begin
               note_mismatch("status", want.status, rsp_status);
            end
            if (rsp_granted_slot !== want.slot) begin
               note_mismatch("granted_slot", want.slot, rsp_granted_slot);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : run_test
      int          burst;
      dir_row_type row;
      for (int i = 0; i < WORD_COUNT; i++) begin
         shadow_map[i] = '0;
      end
      shadow_hint   = 0;
      shadow_enable = 1'b0;

      // directed rows: disabled, range edges, double free, wrap to hint
      add_word_row(OP_ALLOC, '0, 1'b1, ST_DISABLED, '0);
      add_word_row(OP_FREE, '0, 1'b1, ST_FREED, '0);
      add_word_row(OP_FREE, '1, 1'b1, ST_RANGE, '0);
      add_word_row(OP_FREE, slot_index_type'(SLOT_COUNT), 1'b1, ST_RANGE, '0);
      add_word_row(OP_FREE, slot_index_type'(SLOT_COUNT - 1), 1'b1, ST_FREED, '0);
      add_csr_row(1'b1);
      add_word_row(OP_ALLOC, '0, 1'b0, ST_GRANTED, '0);
      add_word_row(OP_ALLOC, '1, 1'b0, ST_GRANTED, '0);
      add_word_row(OP_FREE, slot_index_type'(SLOT_COUNT - 64), 1'b1, ST_FREED, '0);
      add_word_row(OP_FREE, slot_index_type'(SLOT_COUNT - 64), 1'b1, ST_FREED, '0);
      add_word_row(OP_FREE, '0, 1'b1, ST_FREED, '0);
      add_word_row(OP_ALLOC, '0, 1'b1, ST_GRANTED, grant_type'(0));
      add_word_row(OP_ALLOC, '0, 1'b1, ST_GRANTED, grant_type'(1));
      add_word_row(OP_FREE, slot_index_type'(5), 1'b1, ST_FREED, '0);
      add_word_row(OP_FREE, slot_index_type'(64), 1'b1, ST_FREED, '0);
      add_word_row(OP_ALLOC, '0, 1'b0, ST_GRANTED, '0);
      add_word_row(OP_FREE, slot_index_type'(1), 1'b1, ST_FREED, '0);
      add_word_row(OP_ALLOC, '1, 1'b0, ST_GRANTED, '0);
      add_csr_row(1'b0);
      add_word_row(OP_ALLOC, '0, 1'b1, ST_DISABLED, '0);
      add_word_row(OP_FREE, slot_index_type'(12345), 1'b1, ST_RANGE, '0);
      add_word_row(OP_FREE, slot_index_type'(1), 1'b1, ST_FREED, '0);
      add_csr_row(1'b1);
      add_word_row(OP_ALLOC, '0, 1'b0, ST_GRANTED, '0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            set_alloc_enable(row.csr_val);
         end else begin
            send_word(row.op, row.idx, row.has_value, row.status, row.slot, 30);
         end
      end

      // mixed traffic with allocation enabled
      repeat (350) random_item(65, 30);

      // allocation-heavy burst
      repeat (80) random_item(95, 10);

      // churn: a few frees, then one allocation more than freed
      repeat (25) begin
         burst = $urandom_range(4, 1);
         repeat (burst) send_word(OP_FREE, pick_free_index(), 1'b0, ST_GRANTED, '0, 20);
         repeat (burst + 1) begin
            send_word(OP_ALLOC, slot_index_type'($urandom), 1'b0, ST_GRANTED, '0, 20);
         end
      end

      // allocation disabled, frees still act
      set_alloc_enable(1'b0);
      repeat (150) random_item(50, 40);

      // enabled again, then a tail with no idling
      set_alloc_enable(1'b1);
      repeat (200) random_item(45, 30);
      repeat (200) random_item(45, 0);

      // drain and let the longest scan pass
      start <= 1'b0;
      while (replies_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (WORD_COUNT + 8) @(posedge clock);
      if (replies_due.size() != 0) begin
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
